/* rtl/core/ofbw_pkg.sv */
package ofbw_pkg;

   localparam int PANEL_COLUMNS = 128;
   localparam int PANEL_PAGES = 8;
   localparam int STORE_DEPTH = PANEL_COLUMNS * PANEL_PAGES;
   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int PANEL_ROWS = 8 * PANEL_PAGES;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h78;
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA = 8'h40;
   localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH_BASE = 8'h10;
   localparam logic [7:0] COLUMN_LIMIT = 8'd127;

   localparam logic [1:0] FUNC_DRAW_POINT = 2'd0;
   localparam logic [1:0] FUNC_SET_CURSOR = 2'd1;
   localparam logic [1:0] FUNC_WRITE_DATA = 2'd2;

   localparam logic [1:0] BYTE_ADDRESS = 2'd0;
   localparam logic [1:0] BYTE_CONTROL = 2'd1;
   localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

   typedef enum logic [1:0] {
      FRAME_PAGE,
      FRAME_COL_HIGH,
      FRAME_COL_LOW,
      FRAME_DATA
   } frame_type;

   typedef struct packed {
      logic       clear_en;
      logic       load_req;
      logic       cursor_from_req;
      logic       mem_read;
      logic       modify;
      logic       emit;
      frame_type  frame;
      logic [1:0] byte_pos;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic point_off;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/core/ofbw_datapath.sv */
module ofbw_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_column,
   input  logic [7:0]             req_row,
   input  logic                   req_pixel_on,
   input  logic [7:0]             req_data_byte,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   input  ofbw_pkg::dp_cmd_type    cmd,
   output ofbw_pkg::dp_status_type status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_bus_byte,
   output logic                   rsp_frame_start,
   output logic                   rsp_frame_stop,
   output logic                   rsp_run_last
);
   import ofbw_pkg::*;

   logic [7:0]       store_mem [STORE_DEPTH];
   logic [7:0]       rd_data_ff;

   logic [IDX_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic [7:0]       slave_addr_ff, slave_addr_in;
   logic [7:0]       column_ff, column_in;
   logic [7:0]       row_ff, row_in;
   logic             pixel_on_ff, pixel_on_in;
   logic [7:0]       value_ff, value_in;
   logic [2:0]       cursor_page_ff, cursor_page_in;
   logic [6:0]       cursor_column_ff, cursor_column_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_start_ff, rsp_start_in;
   logic             rsp_stop_ff, rsp_stop_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0] point_idx;
   logic [IDX_W-1:0] cursor_idx;
   logic             cursor_in_store;
   logic [7:0]       bit_mask;
   logic [7:0]       modified;
   logic [7:0]       column_next;
   logic [7:0]       payload;
   logic             data_store;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [7:0]       mem_wdata;

   always_comb begin
      point_idx = IDX_W'(32'(row_ff[7:3]) * PANEL_COLUMNS + 32'(column_ff));
      cursor_idx = IDX_W'(32'(cursor_page_ff) * PANEL_COLUMNS + 32'(cursor_column_ff));
      cursor_in_store = (32'(cursor_page_ff) < PANEL_PAGES)
                        && (32'(cursor_column_ff) < PANEL_COLUMNS);
      bit_mask = 8'd1 << row_ff[2:0];
      modified = pixel_on_ff ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
      column_next = {1'b0, cursor_column_ff} + 8'd1;
      if ((32'(column_next) >= PANEL_COLUMNS) || (column_next > COLUMN_LIMIT)) begin
         column_next = 8'd0;
      end
      data_store = cmd.emit && (cmd.frame == FRAME_DATA) && (cmd.byte_pos == BYTE_PAYLOAD);

      status.clear_done = (clear_cnt_ff == IDX_W'(STORE_DEPTH - 1));
      status.point_off = (32'(req_column) >= PANEL_COLUMNS) || (32'(req_row) >= PANEL_ROWS);
      status.out_free = !rsp_valid_ff || rsp_ready;

      mem_we = 1'b0;
      mem_waddr = clear_cnt_ff;
      mem_wdata = 8'd0;
      if (cmd.clear_en) begin
         mem_we = 1'b1;
      end else if (cmd.modify) begin
         mem_we = 1'b1;
         mem_waddr = point_idx;
         mem_wdata = modified;
      end else if (data_store && cursor_in_store) begin
         mem_we = 1'b1;
         mem_waddr = cursor_idx;
         mem_wdata = value_ff;
      end

      clear_cnt_in = cmd.clear_en ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
      slave_addr_in = csr_write_enable ? csr_write_data : slave_addr_ff;

      column_in = column_ff;
      row_in = row_ff;
      pixel_on_in = pixel_on_ff;
      value_in = value_ff;
      if (cmd.load_req) begin
         column_in = req_column;
         row_in = req_row;
         pixel_on_in = req_pixel_on;
         value_in = req_data_byte;
      end else if (cmd.modify) begin
         value_in = modified;
      end

      cursor_page_in = cursor_page_ff;
      cursor_column_in = cursor_column_ff;
      if (cmd.cursor_from_req) begin
         cursor_page_in = req_row[2:0];
         cursor_column_in = req_column[6:0];
      end else if (cmd.modify) begin
         cursor_page_in = row_ff[5:3];
         cursor_column_in = column_ff[6:0];
      end else if (data_store) begin
         cursor_column_in = column_next[6:0];
      end

      unique case (cmd.frame)
         FRAME_PAGE:     payload = CMD_PAGE_BASE | {5'd0, cursor_page_ff};
         FRAME_COL_HIGH: payload = CMD_COL_HIGH_BASE | {5'd0, cursor_column_ff[6:4]};
         FRAME_COL_LOW:  payload = {4'd0, cursor_column_ff[3:0]};
         FRAME_DATA:     payload = value_ff;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in = rsp_byte_ff;
      rsp_start_in = rsp_start_ff;
      rsp_stop_in = rsp_stop_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_start_in = 1'b0;
         rsp_stop_in = 1'b0;
         rsp_last_in = cmd.last;
         case (cmd.byte_pos)
            BYTE_ADDRESS: begin
               rsp_byte_in = slave_addr_ff;
               rsp_start_in = 1'b1;
            end
            BYTE_CONTROL: begin
               rsp_byte_in = (cmd.frame == FRAME_DATA) ? CTRL_DATA : CTRL_COMMAND;
            end
            BYTE_PAYLOAD: begin
               rsp_byte_in = payload;
               rsp_stop_in = 1'b1;
            end
            default: begin
               rsp_byte_in = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= store_mem[point_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         slave_addr_ff <= SLAVE_ADDR_RESET;
         cursor_page_ff <= 3'd0;
         cursor_column_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         slave_addr_ff <= slave_addr_in;
         cursor_page_ff <= cursor_page_in;
         cursor_column_ff <= cursor_column_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff <= column_in;
      row_ff <= row_in;
      pixel_on_ff <= pixel_on_in;
      value_ff <= value_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_start_ff <= rsp_start_in;
      rsp_stop_ff <= rsp_stop_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bus_byte = rsp_byte_ff;
   assign rsp_frame_start = rsp_start_ff;
   assign rsp_frame_stop = rsp_stop_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

/* rtl/core/ofbw_controller.sv */
module ofbw_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_func,
   output logic                   req_ready,
   output ofbw_pkg::dp_cmd_type    cmd,
   input  ofbw_pkg::dp_status_type status
);
   import ofbw_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_MODIFY = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   frame_type  frame_ff, frame_in;
   logic [1:0] byte_pos_ff, byte_pos_in;
   logic       data_after_ff, data_after_in;
   logic       last;

   always_comb begin
      last = (byte_pos_ff == BYTE_PAYLOAD)
             && ((frame_ff == FRAME_DATA) || ((frame_ff == FRAME_COL_LOW) && !data_after_ff));

      state_in = state_ff;
      frame_in = frame_ff;
      byte_pos_in = byte_pos_ff;
      data_after_in = data_after_ff;
      req_ready = 1'b0;

      cmd = '0;
      cmd.frame = frame_ff;
      cmd.byte_pos = byte_pos_ff;
      cmd.last = last;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            byte_pos_in = BYTE_ADDRESS;
            if (req_valid) begin
               unique case (req_func)
                  FUNC_DRAW_POINT: begin
                     if (!status.point_off) begin
                        cmd.load_req = 1'b1;
                        frame_in = FRAME_PAGE;
                        data_after_in = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  FUNC_SET_CURSOR: begin
                     cmd.load_req = 1'b1;
                     cmd.cursor_from_req = 1'b1;
                     frame_in = FRAME_PAGE;
                     data_after_in = 1'b0;
                     state_in = ST_EMIT;
                  end
                  FUNC_WRITE_DATA: begin
                     cmd.load_req = 1'b1;
                     frame_in = FRAME_DATA;
                     data_after_in = 1'b0;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            cmd.modify = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (byte_pos_ff == BYTE_PAYLOAD) begin
                  byte_pos_in = BYTE_ADDRESS;
                  if (last) begin
                     state_in = ST_IDLE;
                  end
                  unique case (frame_ff)
                     FRAME_PAGE:     frame_in = FRAME_COL_HIGH;
                     FRAME_COL_HIGH: frame_in = FRAME_COL_LOW;
                     FRAME_COL_LOW:  frame_in = FRAME_DATA;
                     FRAME_DATA:     frame_in = FRAME_DATA;
                  endcase
               end else begin
                  byte_pos_in = byte_pos_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         frame_ff <= FRAME_PAGE;
         byte_pos_ff <= BYTE_ADDRESS;
         data_after_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         byte_pos_ff <= byte_pos_in;
         data_after_ff <= data_after_in;
      end
   end

endmodule

/* rtl/core/oled_framebuffer_i2c_writer_core.sv */
// Page framebuffer writer for a 128x64 monochrome I2C panel.
// A request on the req_ channel is a draw point, set cursor or write data
// operation. Each produces I2C frames of three bytes (address, control byte,
// payload) on the rsp_ channel, one byte per response, with frame_start on the
// address byte, frame_stop on the payload byte and run_last on the final byte
// of the request. Draw points off the panel and unused codes produce nothing.
// The csr_ port writes the slave address byte. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Requests are handled one at a time. The bytes leave at one per cycle while
// the receiver keeps rsp_ready high: set cursor sends nine bytes, write data
// three, and draw point twelve, with the framebuffer memory read and rewritten
// before the first byte. The block is ready again as the last byte enters the
// output register.
// After reset the framebuffer's 1024 bytes are cleared one byte per cycle,
// during which req_ready stays low; the cursor returns to page 0,
// column 0 and the address byte to 0x78.
// When the receiver stalls, the output register holds its byte and the
// sequencer waits, so no byte is dropped or repeated.
module oled_framebuffer_i2c_writer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_column,
   input  logic [7:0] req_row,
   input  logic       req_pixel_on,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_frame_start,
   output logic       rsp_frame_stop,
   output logic       rsp_run_last,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import ofbw_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ofbw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ofbw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_pixel_on     (req_pixel_on),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_frame_stop   (rsp_frame_stop),
      .rsp_run_last     (rsp_run_last)
   );

   // The last byte of a request always closes a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_run_last) |-> rsp_frame_stop)
      else $error("run_last on a byte that does not end a frame");

   // No frame is a single byte: start and stop never fall on the same byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_frame_start && rsp_frame_stop))
      else $error("frame start and stop on the same byte");

   // A request that produces bytes keeps the input closed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready
       && (req_func == FUNC_SET_CURSOR || req_func == FUNC_WRITE_DATA)) |=> !req_ready)
      else $error("new request taken while frames are pending");

   // The sequencer only loads the output register when it is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("response overwritten before it was taken");

endmodule
